// ===== rtl/bksl_pkg.sv =====
// Shared types and constants for the best-k score list.
package bksl_pkg;

  localparam int SCORE_W = 32;
  localparam int ID_W    = 16;
  localparam int RAW_W   = 30;
  localparam int USE_W   = 16;
  localparam int RANK_W  = 4;
  localparam int KIND_W  = 2;
  localparam int KEEP_W  = 5;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [KEEP_W-1:0] KEEP_RESET = 5'd8;

  // Register index taken from paddr[2]
  localparam logic REG_KEEP_COUNT = 1'b0;

  typedef enum logic [KIND_W-1:0] {
    KIND_OFFER = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [ID_W-1:0]    id;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PEN_MUL,
    S_PEN_ADD,
    S_INS_CMP,
    S_INS_NEW,
    S_TR_RD,
    S_TR_SB,
    S_TR_SCAN,
    S_TR_DEC,
    S_CP_RD,
    S_CP_WR,
    S_RD_ISSUE,
    S_FIN
  } state_t;

endpackage

// ===== rtl/bksl_if.sv =====
// Item and result channel interfaces.
interface bksl_item_if import bksl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [ID_W-1:0]   candidate_id;
  logic [RAW_W-1:0]  raw_score;
  logic [USE_W-1:0]  use_count;
  logic [RANK_W-1:0] read_rank;

  modport source (output valid, kind, candidate_id, raw_score, use_count, read_rank,
                  input ready);
  modport sink   (input valid, kind, candidate_id, raw_score, use_count, read_rank,
                  output ready);
endinterface

interface bksl_result_if import bksl_pkg::*; #(parameter int FILL_W = 5) ();
  logic               valid;
  logic               ready;
  logic               kept;
  logic               entry_valid;
  logic [SCORE_W-1:0] entry_score;
  logic [ID_W-1:0]    entry_id;
  logic [FILL_W-1:0]  fill_level;

  modport source (output valid, kept, entry_valid, entry_score, entry_id, fill_level,
                  input ready);
  modport sink   (input valid, kept, entry_valid, entry_score, entry_id, fill_level,
                  output ready);
endinterface

// ===== rtl/best_k_score_list_unit.sv =====
// Offer: penalty multiply and add, then an insert pass that moves each higher score up one slot.
// A trim follows when the list goes over keep_count: it reads the score at the cut, scans
// the list against it, and compacts the cut group when only part of that group can stay.
// Read: a memory read (none for an empty rank); clear and other kinds go straight to the result.
// One item in flight at a time; item.ready returns the cycle after the result is registered.
// Reset: synchronous, empties the list and sets keep_count to 8; memory is not cleared.
module best_k_score_list_unit import bksl_pkg::*; #(
  parameter int MAX_KEEP = 16
) (
  input  logic               clk,
  input  logic               rst,
  bksl_item_if.sink          item,
  bksl_result_if.source      result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [KEEP_W-1:0] keep_count;

  bksl_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .keep_count (keep_count)
  );

  bksl_core #(.MAX_KEEP(MAX_KEEP)) u_core (
    .clk        (clk),
    .rst        (rst),
    .keep_count (keep_count),
    .item       (item),
    .result     (result)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> !item.ready)
    else $error("item taken while a transaction is in progress");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> int'(result.fill_level) <= MAX_KEEP)
    else $error("fill level above list capacity");

  a_kept_vs_read: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.kept && result.entry_valid))
    else $error("kept and entry_valid both set");

  a_empty_entry: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.entry_valid |-> result.entry_score == '0 && result.entry_id == '0)
    else $error("entry fields not zero without a valid entry");
`endif

endmodule

// ===== rtl/bksl_cfg.sv =====
// APB register block holding keep_count.
module bksl_cfg import bksl_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic [KEEP_W-1:0]  keep_count
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_KEEP_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_count <= KEEP_RESET;
    end else if (wr_en) begin
      keep_count <= pwdata[KEEP_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_KEEP_COUNT) ? PDATA_W'(keep_count) : '0;

endmodule

// ===== rtl/bksl_penalty.sv =====
// Two-stage penalized score: raw + raw*uses/2, saturated to 32 bits.
module bksl_penalty import bksl_pkg::*; (
  input  logic               clk,
  input  logic [RAW_W-1:0]   raw_score,
  input  logic [USE_W-1:0]   use_count,
  output logic [SCORE_W-1:0] score
);

  localparam int PROD_W = RAW_W + USE_W;

  logic [PROD_W-1:0] prod;
  logic [RAW_W-1:0]  raw_d;
  logic [PROD_W:0]   sum;

  assign sum = (PROD_W+1)'(raw_d) + (PROD_W+1)'(prod >> 1);

  always_ff @(posedge clk) begin
    prod  <= PROD_W'(raw_score) * PROD_W'(use_count);
    raw_d <= raw_score;
    if (|sum[PROD_W:SCORE_W]) begin
      score <= '1;
    end else begin
      score <= sum[SCORE_W-1:0];
    end
  end

endmodule

// ===== rtl/bksl_core.sv =====
// Sequencer, entry memory and shared score comparator of the best-k list.
module bksl_core import bksl_pkg::*; #(
  parameter int MAX_KEEP = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [KEEP_W-1:0] keep_count,
  bksl_item_if.sink         item,
  bksl_result_if.source     result
);

  localparam int CW = $clog2(MAX_KEEP + 2);
  localparam int AW = $clog2(MAX_KEEP + 1);
  localparam int FW = KEEP_W;
  localparam int LW = (CW > KEEP_W) ? CW : KEEP_W;
  localparam int XW = (CW > RANK_W) ? CW : RANK_W;

  state_t state, state_next;

  entry_t mem [0:MAX_KEEP];
  entry_t rd_q;
  entry_t mem_wdata;
  entry_t new_entry;
  logic   mem_we, mem_re;
  logic [CW-1:0] rd_idx, wr_idx;

  logic [CW-1:0] cnt, limit, ptr, wp, pos, f_cnt, le_cnt, h_idx;
  logic [LW-1:0] kc_x;
  logic [KIND_W-1:0]  kind_q;
  logic [ID_W-1:0]    id_q;
  logic [RAW_W-1:0]   raw_q;
  logic [USE_W-1:0]   use_q;
  logic [RANK_W-1:0]  rank_q;
  logic [SCORE_W-1:0] sb, pen_score, cmp_b;
  logic kept_r, valid_r;
  logic cmp_lt, cmp_eq, cmp_gt;
  logic accept, rank_ok, trim_need, out_free, load;

  bksl_penalty u_penalty (
    .clk       (clk),
    .raw_score (raw_q),
    .use_count (use_q),
    .score     (pen_score)
  );

  // Clamp keep_count into 1..MAX_KEEP
  always_comb begin
    kc_x = LW'(keep_count);
    if (kc_x == '0) begin
      limit = CW'(1);
    end else if (kc_x > LW'(MAX_KEEP)) begin
      limit = CW'(MAX_KEEP);
    end else begin
      limit = CW'(kc_x);
    end
  end

  assign accept    = (state == S_IDLE) && item.valid;
  assign rank_ok   = XW'(item.read_rank) < XW'(cnt);
  assign trim_need = cnt >= limit;
  assign out_free  = !result.valid || result.ready;
  assign load      = (state == S_FIN) && out_free;
  assign new_entry = '{score: pen_score, id: id_q};

  // Shared comparator
  assign cmp_b  = (state == S_TR_SCAN) ? sb : pen_score;
  assign cmp_lt = rd_q.score < cmp_b;
  assign cmp_eq = rd_q.score == cmp_b;
  assign cmp_gt = !cmp_lt && !cmp_eq;

  // First kept index of the tied group at the cut
  assign h_idx = (le_cnt > limit) ? (le_cnt - limit) + f_cnt : f_cnt;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (item.valid) begin
          case (item.kind)
            KIND_OFFER: state_next = S_PEN_MUL;
            KIND_READ:  state_next = rank_ok ? S_RD_ISSUE : S_FIN;
            default:    state_next = S_FIN;
          endcase
        end
      end
      S_PEN_MUL: state_next = S_PEN_ADD;
      S_PEN_ADD: state_next = (cnt == '0) ? S_INS_NEW : S_INS_CMP;
      S_INS_CMP: begin
        if (cmp_gt) begin
          if (ptr == '0) state_next = S_INS_NEW;
        end else begin
          state_next = trim_need ? S_TR_RD : S_FIN;
        end
      end
      S_INS_NEW: state_next = trim_need ? S_TR_RD : S_FIN;
      S_TR_RD:   state_next = S_TR_SB;
      S_TR_SB:   state_next = S_TR_SCAN;
      S_TR_SCAN: begin
        if (ptr == cnt - 1'b1) state_next = S_TR_DEC;
      end
      S_TR_DEC:  state_next = (le_cnt > limit) ? S_CP_RD : S_FIN;
      S_CP_RD:   state_next = S_CP_WR;
      S_CP_WR: begin
        if (wp == limit - 1'b1) state_next = S_FIN;
      end
      S_RD_ISSUE: state_next = S_FIN;
      S_FIN: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    item.ready = (state == S_IDLE);
    mem_re     = 1'b0;
    mem_we     = 1'b0;
    rd_idx     = ptr;
    wr_idx     = ptr + 1'b1;
    mem_wdata  = rd_q;
    case (state)
      S_PEN_ADD: begin
        mem_re = 1'b1;
        rd_idx = cnt - 1'b1;
      end
      S_INS_CMP: begin
        mem_re    = 1'b1;
        rd_idx    = ptr - 1'b1;
        mem_we    = 1'b1;
        mem_wdata = cmp_gt ? rd_q : new_entry;
      end
      S_INS_NEW: begin
        mem_we    = 1'b1;
        wr_idx    = '0;
        mem_wdata = new_entry;
      end
      S_TR_RD: begin
        mem_re = 1'b1;
        rd_idx = limit - 1'b1;
      end
      S_TR_SB: begin
        mem_re = 1'b1;
        rd_idx = '0;
      end
      S_TR_SCAN: begin
        mem_re = 1'b1;
        rd_idx = ptr + 1'b1;
      end
      S_CP_RD: begin
        mem_re = 1'b1;
      end
      S_CP_WR: begin
        mem_re = 1'b1;
        mem_we = 1'b1;
        wr_idx = wp;
      end
      S_RD_ISSUE: begin
        mem_re = 1'b1;
        rd_idx = CW'(rank_q);
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_idx[AW-1:0]] <= mem_wdata;
    if (mem_re) rd_q <= mem[rd_idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (accept && item.kind == KIND_CLEAR) cnt <= '0;
        end
        S_INS_CMP: begin
          if (!cmp_gt) cnt <= cnt + 1'b1;
        end
        S_INS_NEW: cnt <= cnt + 1'b1;
        S_TR_DEC:  cnt <= limit;
        default:   cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          kind_q  <= item.kind;
          id_q    <= item.candidate_id;
          raw_q   <= item.raw_score;
          use_q   <= item.use_count;
          rank_q  <= item.read_rank;
          kept_r  <= 1'b0;
          valid_r <= (item.kind == KIND_READ) && rank_ok;
        end
      end
      S_PEN_ADD: begin
        ptr <= cnt - 1'b1;
        pos <= '0;
      end
      S_INS_CMP: begin
        if (cmp_gt) begin
          if (ptr == '0) begin
            pos <= '0;
          end else begin
            ptr <= ptr - 1'b1;
          end
        end else begin
          pos    <= ptr + 1'b1;
          kept_r <= 1'b1;
        end
      end
      S_INS_NEW: kept_r <= 1'b1;
      S_TR_SB: begin
        sb     <= rd_q.score;
        ptr    <= '0;
        f_cnt  <= '0;
        le_cnt <= '0;
      end
      S_TR_SCAN: begin
        f_cnt  <= f_cnt + CW'(cmp_lt);
        le_cnt <= le_cnt + CW'(cmp_lt || cmp_eq);
        ptr    <= ptr + 1'b1;
      end
      S_TR_DEC: begin
        // Survive below the tied group, or among its newest members
        kept_r <= (pos < f_cnt) || ((pos >= h_idx) && (pos < le_cnt));
        ptr    <= h_idx;
        wp     <= f_cnt;
      end
      S_CP_RD: ptr <= ptr + 1'b1;
      S_CP_WR: begin
        ptr <= ptr + 1'b1;
        wp  <= wp + 1'b1;
      end
      default: begin
        ptr <= ptr;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.kept        <= kept_r && (kind_q == KIND_OFFER);
      result.entry_valid <= valid_r;
      result.entry_score <= valid_r ? rd_q.score : '0;
      result.entry_id    <= valid_r ? rd_q.id : '0;
      result.fill_level  <= FW'(cnt);
    end
  end

endmodule

// ===== sim/bksl_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the best-k score list: predicts each result and compares it field by field.
module bksl_checker import bksl_pkg::*; #(
  parameter int MAX_KEEP = 16
) (
  input  logic               clk,
  input  logic               rst,
  bksl_item_if               item,
  bksl_result_if             result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 outstanding
);

  typedef struct packed {
    logic               kept;
    logic               entry_valid;
    logic [SCORE_W-1:0] score;
    logic [ID_W-1:0]    id;
    logic [KEEP_W-1:0]  fill;
  } list_result_t;

  logic [KEEP_W-1:0]  keep_reg;
  logic [SCORE_W-1:0] score_list [MAX_KEEP+1];
  logic [ID_W-1:0]    id_list [MAX_KEEP+1];
  int                 held;
  list_result_t       pending_results [$];
  list_result_t       want;
  int                 errors = 0;

  assign fail_count = errors;

  function automatic logic [SCORE_W-1:0] penalised_score(logic [RAW_W-1:0] raw,
                                                         logic [USE_W-1:0] uses);
    logic [63:0] sum;
    sum = 64'(raw) + ((64'(raw) * 64'(uses)) >> 1);
    return (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[SCORE_W-1:0];
  endfunction

  function automatic void drop_rank(int r);
    for (int j = r; j + 1 < held; j++) begin
      score_list[j] = score_list[j+1];
      id_list[j]    = id_list[j+1];
    end
    held--;
  endfunction

  function automatic list_result_t list_update(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id,
                                               logic [RAW_W-1:0] raw, logic [USE_W-1:0] uses,
                                               logic [RANK_W-1:0] rank);
    list_result_t       res;
    logic [SCORE_W-1:0] s;
    int                 lim;
    int                 pos;
    int                 r;
    logic               present;
    res = '0;
    case (kind)
      KIND_OFFER: begin
        s   = penalised_score(raw, uses);
        lim = (keep_reg == 0) ? 1 : ((keep_reg > MAX_KEEP) ? MAX_KEEP : int'(keep_reg));
        // equal scores stay ahead of the newcomer
        pos = 0;
        while (pos < held && score_list[pos] <= s) pos++;
        for (int i = held; i > pos; i--) begin
          score_list[i] = score_list[i-1];
          id_list[i]    = id_list[i-1];
        end
        score_list[pos] = s;
        id_list[pos]    = id;
        held++;
        present = 1'b1;
        // drop the oldest of the highest-score group until the list fits
        while (held > lim) begin
          r = held - 1;
          while (r > 0 && score_list[r-1] == score_list[held-1]) r--;
          if (present) begin
            if (r == pos) present = 1'b0;
            else if (r < pos) pos--;
          end
          drop_rank(r);
        end
        res.kept = present;
      end
      KIND_READ: begin
        if (rank < held) begin
          res.entry_valid = 1'b1;
          res.score       = score_list[rank];
          res.id          = id_list[rank];
        end
      end
      KIND_CLEAR: held = 0;
      default: ;
    endcase
    res.fill = held[KEEP_W-1:0];
    return res;
  endfunction

  function automatic void check_field(string name, logic [SCORE_W-1:0] exp_val,
                                      logic [SCORE_W-1:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_val, act_val);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      keep_reg = KEEP_RESET;
      held     = 0;
      pending_results.delete();
      outstanding <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == REG_KEEP_COUNT)
        keep_reg = pwdata[KEEP_W-1:0];
      if (item.valid && item.ready)
        pending_results.insert(pending_results.size(),
                               list_update(item.kind, item.candidate_id, item.raw_score,
                                           item.use_count, item.read_rank));
      if (result.valid && result.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result transaction with nothing expected", $time);
          errors++;
        end else begin
          want = pending_results[0];
          pending_results.delete(0);
          check_field("kept", SCORE_W'(want.kept), SCORE_W'(result.kept));
          check_field("entry_valid", SCORE_W'(want.entry_valid),
                      SCORE_W'(result.entry_valid));
          check_field("entry_score", want.score, result.entry_score);
          check_field("entry_id", SCORE_W'(want.id), SCORE_W'(result.entry_id));
          check_field("fill_level", SCORE_W'(want.fill), SCORE_W'(result.fill_level));
        end
      end
      outstanding <= pending_results.size();
    end
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// Top of the best-k score list testbench: clock, reset, stimulus, register writes and verdict.
module testbench;
  import bksl_pkg::*;

  localparam int MAX_KEEP       = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int PHASES         = 9;
  localparam int PHASE_ITEMS    = 110;

  localparam logic [KIND_W-1:0]  KIND_UNUSED = 2'd3;
  localparam logic [PADDR_W-1:0] KEEP_ADDR   = 3'd0;
  localparam logic [PADDR_W-1:0] SPARE_ADDR  = 3'd4;  // past the last register

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  int                 fail_count;
  int                 outstanding;
  int                 idle_cycles = 0;
  int                 stall_left = 0;
  bit                 sender_gaps = 1'b1;
  bit                 receiver_stalls = 1'b1;

  bksl_item_if   item_if ();
  bksl_result_if res_if ();

  best_k_score_list_unit #(.MAX_KEEP(MAX_KEEP)) u_top (
    .clk     (clk),
    .rst     (rst),
    .item    (item_if),
    .result  (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  bksl_checker #(.MAX_KEEP(MAX_KEEP)) u_chk (
    .clk         (clk),
    .rst         (rst),
    .item        (item_if),
    .result      (res_if),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int gap_length();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(6, 30);
  endfunction

  always @(posedge clk) begin
    if (stall_left != 0) begin
      res_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      res_if.ready <= 1'b1;
      if (receiver_stalls && $urandom_range(0, 3) == 0) stall_left <= gap_length();
    end
  end

  always @(posedge clk) begin
    if (rst || (item_if.valid && item_if.ready) || (res_if.valid && res_if.ready) ||
        (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_item(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id,
                           logic [RAW_W-1:0] raw, logic [USE_W-1:0] uses,
                           logic [RANK_W-1:0] rank);
    int gap;
    gap = (sender_gaps && $urandom_range(0, 9) < 3) ? gap_length() : 0;
    if (gap != 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_if.valid        <= 1'b1;
    item_if.kind         <= kind;
    item_if.candidate_id <= id;
    item_if.raw_score    <= raw;
    item_if.use_count    <= uses;
    item_if.read_rank    <= rank;
    do @(posedge clk); while (!item_if.ready);
  endtask

  task automatic offer(logic [ID_W-1:0] id, logic [RAW_W-1:0] raw, logic [USE_W-1:0] uses);
    send_item(KIND_OFFER, id, raw, uses, RANK_W'($urandom));
  endtask

  task automatic read_at(logic [RANK_W-1:0] rank);
    send_item(KIND_READ, ID_W'($urandom), RAW_W'($urandom), USE_W'($urandom), rank);
  endtask

  task automatic send_other(logic [KIND_W-1:0] kind);
    send_item(kind, ID_W'($urandom), RAW_W'($urandom), USE_W'($urandom), RANK_W'($urandom));
  endtask

  task automatic send_random_item();
    int                 pick;
    logic [KIND_W-1:0]  kind;
    logic [RAW_W-1:0]   raw;
    logic [USE_W-1:0]   uses;
    pick = $urandom_range(0, 99);
    if (pick < 58) kind = KIND_OFFER;
    else if (pick < 94) kind = KIND_READ;
    else if (pick < 97) kind = KIND_CLEAR;
    else kind = KIND_UNUSED;
    // small scores give ties, wide ones mostly saturate
    case ($urandom_range(0, 2))
      0: begin
        raw  = RAW_W'($urandom_range(0, 15));
        uses = USE_W'($urandom_range(0, 3));
      end
      1: begin
        raw  = RAW_W'($urandom);
        uses = USE_W'($urandom);
      end
      default: begin
        raw  = RAW_W'($urandom_range(0, 1 << 20));
        uses = USE_W'($urandom_range(0, 8));
      end
    endcase
    send_item(kind, ID_W'($urandom), raw, uses, RANK_W'($urandom));
  endtask

  task automatic offer_small();
    offer(ID_W'($urandom), RAW_W'($urandom_range(0, 20)), USE_W'($urandom_range(0, 2)));
  endtask

  // Hold the sender until every result is back, then let the block settle.
  task automatic wait_idle();
    item_if.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [KEEP_W-1:0] keep;
    rst                  <= 1'b1;
    item_if.valid        <= 1'b0;
    item_if.kind         <= KIND_OFFER;
    item_if.candidate_id <= '0;
    item_if.raw_score    <= '0;
    item_if.use_count    <= '0;
    item_if.read_rank    <= '0;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: read of an empty list, penalty extremes, ties, unused kind, overflow, clear
    read_at(4'd0);
    offer(16'hFFFF, 30'h3FFF_FFFF, 16'hFFFF);
    offer(16'h0000, 30'h0, 16'h0);
    offer(16'h0001, 30'h3FFF_FFFF, 16'h0);
    offer(16'h0002, 30'h3FFF_FFFF, 16'h1);
    offer(16'h0003, 30'h3, 16'h1);
    offer(16'h0004, 30'h1, 16'h1);
    offer(16'h0005, 30'h0, 16'h0);
    send_other(KIND_UNUSED);
    for (int r = 0; r < 8; r++) read_at(RANK_W'(r));
    offer(16'h0006, 30'h2AAA_AAAA, 16'h5555);
    offer(16'h0007, 30'h1555_5555, 16'hAAAA);
    offer(16'h0008, 30'h5, 16'h0);
    read_at(4'd7);
    read_at(4'd15);
    send_other(KIND_CLEAR);
    read_at(4'd0);

    // write past the register list, then lower the keep count below the list's fill level
    wait_idle();
    write_reg(SPARE_ADDR, 32'hFFFF_FFFF);
    write_reg(KEEP_ADDR, 32'd16);
    for (int n = 0; n < 12; n++) offer_small();
    wait_idle();
    write_reg(KEEP_ADDR, 32'd3);
    for (int r = 0; r < 13; r++) read_at(RANK_W'(r));
    offer_small();
    read_at(4'd3);

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      case (p)
        0: keep = 5'd1;
        1: keep = 5'd0;
        2: keep = 5'd16;
        3: keep = 5'd31;
        4: keep = 5'd2;
        default: keep = KEEP_W'($urandom_range(0, 31));
      endcase
      write_reg(KEEP_ADDR, ($urandom & ~32'h1F) | 32'(keep));
      sender_gaps     = (p != 0) && ($urandom_range(0, 3) != 0);
      receiver_stalls = (p != 0) && ($urandom_range(0, 3) != 0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 199) == 0) wait_idle();
        send_random_item();
      end
    end
    wait_idle();

    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/bksl_pkg.sv
rtl/bksl_if.sv
rtl/bksl_cfg.sv
rtl/bksl_penalty.sv
rtl/bksl_core.sv
rtl/best_k_score_list_unit.sv
sim/bksl_checker.sv
sim/testbench.sv
